// File: sv/hub75_pkg.sv
`default_nettype none

package hub75_pkg;

    // panel geometry and color depth
    localparam int FRAME_ROWS  = 32;
    localparam int FRAME_COLS  = 64;
    localparam int COLOR_BITS  = 3;

    localparam int SCAN_LINES  = FRAME_ROWS / 2;
    localparam int LINE_SLOTS  = 2 * FRAME_COLS;
    localparam int STORE_DEPTH = SCAN_LINES * FRAME_COLS;

    localparam int ADDR_W = $clog2(STORE_DEPTH);
    localparam int LINE_W = $clog2(SCAN_LINES);
    localparam int SLOT_W = $clog2(LINE_SLOTS);

    // fixed input and pin field widths
    localparam int ROW_W      = 5;
    localparam int COL_W      = 6;
    localparam int PIN_COLOR_W = 3;
    localparam int PIN_LINE_W = 4;

    // queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    // input item kinds
    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_TICK  = 1'b1;

    typedef enum logic [1:0] {
        OP_WR_UPPER,
        OP_WR_LOWER,
        OP_TICK
    } op_t;

    // classified command passed from front to back
    typedef struct packed {
        op_t                     op;
        logic [ADDR_W-1:0]       addr;
        logic [COLOR_BITS-1:0]   color;
        logic [PIN_LINE_W-1:0]   line;
        logic                    shift_clock;
        logic                    latch;
    } cmd_t;

    // one pin word
    typedef struct packed {
        logic [PIN_COLOR_W-1:0]  upper_color;
        logic [PIN_COLOR_W-1:0]  lower_color;
        logic [PIN_LINE_W-1:0]   line_address;
        logic                    shift_clock;
        logic                    latch;
    } pin_t;

endpackage

`default_nettype wire

// File: sv/hub75_front.sv
`default_nettype none

module hub75_front
    import hub75_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              accept,
    input  wire logic              kind,
    input  wire logic [ROW_W-1:0]  pixel_row,
    input  wire logic [COL_W-1:0]  pixel_column,
    input  wire logic [2:0]        pixel_color,
    output logic                   push,
    output cmd_t                   cmd
);

    logic [LINE_W-1:0] line_reg, line_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;

    logic [ROW_W-1:0]  panel_row;
    logic [ROW_W-1:0]  half_row;
    logic              is_upper;
    logic              in_frame;
    logic              last_slot;
    logic              last_line;
    logic [ADDR_W-1:0] wr_addr;

    // row remap: first row of each half moves to the end of the upper half or frame
    always_comb
    begin
        if (pixel_row == '0)
            panel_row = ROW_W'(SCAN_LINES - 1);
        else if (pixel_row == ROW_W'(SCAN_LINES))
            panel_row = ROW_W'(FRAME_ROWS - 1);
        else
            panel_row = pixel_row - ROW_W'(1);
        is_upper = int'(panel_row) < SCAN_LINES;
        half_row = is_upper ? panel_row : (panel_row - ROW_W'(SCAN_LINES));
        in_frame = (int'(pixel_row) < FRAME_ROWS) && (int'(pixel_column) < FRAME_COLS);
        wr_addr  = ADDR_W'(half_row) * ADDR_W'(FRAME_COLS) + ADDR_W'(pixel_column);
    end

    // scan position bookkeeping
    always_comb
    begin
        last_slot = slot_reg == SLOT_W'(LINE_SLOTS - 1);
        last_line = line_reg == LINE_W'(SCAN_LINES - 1);
        line_next = line_reg;
        slot_next = slot_reg;
        addr_next = addr_reg;
        if (accept && kind == KIND_TICK)
        begin
            if (last_slot)
            begin
                slot_next = '0;
                line_next = last_line ? '0 : line_reg + LINE_W'(1);
            end
            else
            begin
                slot_next = slot_reg + SLOT_W'(1);
            end
            if (last_slot && last_line)
                addr_next = '0;
            else if (slot_reg[0])
                addr_next = addr_reg + ADDR_W'(1);
        end
    end

    // command build
    always_comb
    begin
        cmd.color       = COLOR_BITS'(pixel_color);
        cmd.line        = PIN_LINE_W'(line_reg);
        cmd.shift_clock = !slot_reg[0];
        cmd.latch       = int'(slot_reg) >= LINE_SLOTS - 2;
        if (kind == KIND_TICK)
        begin
            cmd.op   = OP_TICK;
            cmd.addr = addr_reg;
            push     = accept;
        end
        else
        begin
            cmd.op   = is_upper ? OP_WR_UPPER : OP_WR_LOWER;
            cmd.addr = wr_addr;
            push     = accept && in_frame;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_reg <= '0;
            slot_reg <= '0;
            addr_reg <= '0;
        end
        else
        begin
            line_reg <= line_next;
            slot_reg <= slot_next;
            addr_reg <= addr_next;
        end
    end

endmodule

`default_nettype wire

// File: sv/hub75_cmd_fifo.sv
`default_nettype none

module hub75_cmd_fifo
    import hub75_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  push,
    input  wire cmd_t  push_cmd,
    output logic       not_full,
    input  wire logic  pop,
    output logic       pop_valid,
    output cmd_t       pop_cmd
);

    cmd_t                   entries [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CNT_W-1:0] count_reg, count_next;

    assign not_full  = count_reg != QUEUE_CNT_W'(QUEUE_DEPTH);
    assign pop_valid = count_reg != '0;
    assign pop_cmd   = entries[rd_ptr_reg];

    // pointer and fill update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                            : wr_ptr_reg + QUEUE_PTR_W'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                            : rd_ptr_reg + QUEUE_PTR_W'(1);
        if (push && !pop)
            count_next = count_reg + QUEUE_CNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - QUEUE_CNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entries[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

// File: sv/hub75_back.sv
`default_nettype none

module hub75_back
    import hub75_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  q_valid,
    input  wire cmd_t  q_cmd,
    output logic       q_pop,
    output logic       clearing,
    output logic       out_valid,
    input  wire logic  out_ready,
    output pin_t       out_pin
);

    localparam int OUT_DEPTH = 4;
    localparam int OUT_PTR_W = $clog2(OUT_DEPTH);
    localparam int OUT_CNT_W = $clog2(OUT_DEPTH + 2);

    // pixel store, one memory per half
    logic [COLOR_BITS-1:0] upper_mem [STORE_DEPTH];
    logic [COLOR_BITS-1:0] lower_mem [STORE_DEPTH];

    logic                  clr_active_reg, clr_active_next;
    logic [ADDR_W-1:0]     clr_addr_reg, clr_addr_next;

    logic                  rd_valid_reg;
    logic [COLOR_BITS-1:0] upper_rd_reg;
    logic [COLOR_BITS-1:0] lower_rd_reg;
    cmd_t                  rd_cmd_reg;

    pin_t                  out_buf [OUT_DEPTH];
    logic [OUT_PTR_W-1:0]  out_wr_reg, out_wr_next;
    logic [OUT_PTR_W-1:0]  out_rd_reg, out_rd_next;
    logic [OUT_CNT_W-1:0]  out_cnt_reg, out_cnt_next;

    logic                  is_tick;
    logic                  credit_ok;
    logic                  rd_en;
    logic                  we_upper;
    logic                  we_lower;
    logic [ADDR_W-1:0]     wr_addr;
    logic [COLOR_BITS-1:0] wr_color;
    logic                  out_take;
    pin_t                  new_pin;

    // issue: writes go at once, reads need room in the output buffer
    always_comb
    begin
        is_tick   = q_cmd.op == OP_TICK;
        credit_ok = (out_cnt_reg + OUT_CNT_W'(rd_valid_reg)) < OUT_CNT_W'(OUT_DEPTH);
        q_pop     = q_valid && !clr_active_reg && (!is_tick || credit_ok);
        rd_en     = q_pop && is_tick;
        we_upper  = clr_active_reg;
        we_lower  = clr_active_reg;
        wr_addr   = clr_active_reg ? clr_addr_reg : q_cmd.addr;
        wr_color  = clr_active_reg ? '0 : q_cmd.color;
        case (q_cmd.op)
            OP_WR_UPPER: we_upper = we_upper || q_pop;
            OP_WR_LOWER: we_lower = we_lower || q_pop;
            OP_TICK:     ;
            default:     ;
        endcase
    end

    assign clearing = clr_active_reg;

    // clearing sweep after reset
    always_comb
    begin
        clr_active_next = clr_active_reg;
        clr_addr_next   = clr_addr_reg;
        if (clr_active_reg)
        begin
            clr_addr_next = clr_addr_reg + ADDR_W'(1);
            if (clr_addr_reg == ADDR_W'(STORE_DEPTH - 1))
                clr_active_next = 1'b0;
        end
    end

    // store access with registered read
    always_ff @(posedge clk)
    begin
        if (we_upper)
            upper_mem[wr_addr] <= wr_color;
        if (we_lower)
            lower_mem[wr_addr] <= wr_color;
        if (rd_en)
        begin
            upper_rd_reg <= upper_mem[q_cmd.addr];
            lower_rd_reg <= lower_mem[q_cmd.addr];
            rd_cmd_reg   <= q_cmd;
        end
    end

    // pin word assembly
    always_comb
    begin
        new_pin.upper_color  = PIN_COLOR_W'(upper_rd_reg);
        new_pin.lower_color  = PIN_COLOR_W'(lower_rd_reg);
        new_pin.line_address = rd_cmd_reg.line;
        new_pin.shift_clock  = rd_cmd_reg.shift_clock;
        new_pin.latch        = rd_cmd_reg.latch;
    end

    // output buffer
    assign out_valid = out_cnt_reg != '0;
    assign out_pin   = out_buf[out_rd_reg];
    assign out_take  = out_valid && out_ready;

    always_comb
    begin
        out_wr_next  = out_wr_reg;
        out_rd_next  = out_rd_reg;
        out_cnt_next = out_cnt_reg;
        if (rd_valid_reg)
            out_wr_next = out_wr_reg + OUT_PTR_W'(1);
        if (out_take)
            out_rd_next = out_rd_reg + OUT_PTR_W'(1);
        if (rd_valid_reg && !out_take)
            out_cnt_next = out_cnt_reg + OUT_CNT_W'(1);
        else if (out_take && !rd_valid_reg)
            out_cnt_next = out_cnt_reg - OUT_CNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (rd_valid_reg)
            out_buf[out_wr_reg] <= new_pin;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
            rd_valid_reg   <= 1'b0;
            out_wr_reg     <= '0;
            out_rd_reg     <= '0;
            out_cnt_reg    <= '0;
        end
        else
        begin
            clr_active_reg <= clr_active_next;
            clr_addr_reg   <= clr_addr_next;
            rd_valid_reg   <= rd_en;
            out_wr_reg     <= out_wr_next;
            out_rd_reg     <= out_rd_next;
            out_cnt_reg    <= out_cnt_next;
        end
    end

    // nothing leaves the queue while the store is being cleared
    assert property (@(posedge clk) disable iff (!rst_n) clr_active_reg |-> !q_pop)
        else $error("command issued during store clear");

    // a read in flight always has a free output slot waiting
    assert property (@(posedge clk) disable iff (!rst_n)
        rd_valid_reg |-> (out_cnt_reg < OUT_CNT_W'(OUT_DEPTH)) || out_take)
        else $error("output buffer overflow");

    // every registered read comes from a tick issued the cycle before
    assert property (@(posedge clk) disable iff (!rst_n)
        rd_valid_reg |-> $past(q_pop && q_cmd.op == OP_TICK))
        else $error("read data without a tick");

    // reserved output slots never exceed the buffer
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_cnt_reg + OUT_CNT_W'(rd_valid_reg)) <= OUT_CNT_W'(OUT_DEPTH))
        else $error("output credit exceeded");

endmodule

`default_nettype wire

// File: sv/hub75_panel_refresh_core.sv
// a tick item goes through the command queue, the registered store read and the output buffer to m_tdata
// throughput: one item per cycle on both sides when not stalled; pixel writes and ticks mix freely
// pixel writes pass through the same queue, so a later tick always sees earlier writes
// reset: scan restarts at line 0 slot 0; then the pixel store is swept to black,
// one entry per cycle over all 1024 entries, with s_tready low until the sweep ends
`default_nettype none

module hub75_panel_refresh_core
    import hub75_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // pixel_row[4:0], pixel_column[10:5], pixel_color[13:11]
    input  wire logic        s_tuser,   // kind[0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata    // upper_color[2:0], lower_color[5:3], line_address[9:6],
                                        // shift_clock[10], latch[11], output_enable[12]
);

    logic  accept;
    logic  push;
    logic  q_not_full;
    logic  q_valid;
    logic  q_pop;
    logic  clearing;
    cmd_t  push_cmd;
    cmd_t  q_cmd;
    pin_t  out_pin;

    // input handshake
    assign s_tready = q_not_full && !clearing;
    assign accept   = s_tvalid && s_tready;

    hub75_front u_front
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .kind         (s_tuser),
        .pixel_row    (s_tdata[4:0]),
        .pixel_column (s_tdata[10:5]),
        .pixel_color  (s_tdata[13:11]),
        .push         (push),
        .cmd          (push_cmd)
    );

    hub75_cmd_fifo u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_cmd  (push_cmd),
        .not_full  (q_not_full),
        .pop       (q_pop),
        .pop_valid (q_valid),
        .pop_cmd   (q_cmd)
    );

    hub75_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_cmd     (q_cmd),
        .q_pop     (q_pop),
        .clearing  (clearing),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_pin   (out_pin)
    );

    // pin word packing, output enable follows latch
    assign m_tdata = {3'b000,
                      out_pin.latch,
                      out_pin.latch,
                      out_pin.shift_clock,
                      out_pin.line_address,
                      out_pin.lower_color,
                      out_pin.upper_color};

endmodule

`default_nettype wire
